// File: rtl/ppmd_pkg.sv
// shared types and constants for the point to polyline distance block
package ppmd_pkg;

  localparam int MAG_W  = 20;
  localparam int COL_W  = MAG_W + 1;
  localparam int DIF_W  = MAG_W + 2;
  localparam int DIST_W = 42;
  localparam int OUT_W  = 41;
  localparam int PRD_W  = 2 * DIF_W;
  localparam int NUM_W  = 43;
  localparam int DEN_W  = 44;
  localparam int CFG_IDX_W = 3;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [OUT_W-1:0]  OUT_MAX  = {OUT_W{1'b1}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OBS_V     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OBS_COL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_V_OFFSET  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COL_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAG_LIMIT = 3'd4;

  // 0.06, 0.1 and 2 mag at 12 fraction bits
  localparam logic [MAG_W-1:0] V_OFFSET_RST  = 20'd246;
  localparam logic [MAG_W-1:0] COL_LIMIT_RST = 20'd410;
  localparam logic [MAG_W-1:0] MAG_LIMIT_RST = 20'd8192;

  typedef logic signed [MAG_W-1:0] mag_t;
  typedef logic signed [COL_W-1:0] col_t;
  typedef logic signed [DIF_W-1:0] dif_t;
  typedef logic [DIST_W-1:0]       dist_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num_hi;
    logic [NUM_W-1:0]  num_lo;
    logic [DEN_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

  function automatic logic [DIF_W-1:0] abs_dif(dif_t x);
    abs_dif = x[DIF_W-1] ? (~x + 1'b1) : x;
  endfunction

  // saturating sum of two squares
  function automatic dist_t sat_add(dist_t a, logic [PRD_W-1:0] b);
    logic [PRD_W:0] s;
    s = {3'b0, a} + {1'b0, b};
    sat_add = (s > {3'b0, DIST_MAX}) ? DIST_MAX : s[DIST_W-1:0];
  endfunction

endpackage

// File: rtl/ppmd_mul.sv
// shared registered 22 x 22 unsigned multiplier
module ppmd_mul import ppmd_pkg::*; (
  input  logic             clk,
  input  logic [DIF_W-1:0] op_a,
  input  logic [DIF_W-1:0] op_b,
  output logic [PRD_W-1:0] prod
);

  logic [PRD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule

// File: rtl/ppmd_div.sv
// restoring divider, one quotient bit per cycle
module ppmd_div import ppmd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic             busy_r;
  logic [5:0]       cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] lo_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  assign trial = {rem_r, lo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(NUM_W);
        rem_r  <= {1'b0, req.num_hi};
        lo_r   <= req.num_lo;
        den_r  <= req.den;
        quo_r  <= '0;
      end else if (busy_r) begin
        if (trial >= {1'b0, den_r}) begin
          rem_r <= diff[DEN_W-1:0];
          quo_r <= {quo_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= trial[DEN_W-1:0];
          quo_r <= {quo_r[NUM_W-2:0], 1'b0};
        end
        lo_r  <= {lo_r[NUM_W-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// File: rtl/point_to_polyline_min_distance_core.sv
// Nearest approach of a streamed curve to one observed star in colour / V space.
// One curve point is a request; the block stays busy with it (in_stall high) through
// the distance states, and longer when the point closes a qualifying local minimum, since
// each of the two segments then needs five products on the one shared 22x22 multiplier
// and a 43-step restoring division (a segment settled by an endpoint needs only its two
// squares and skips the division). A request ending a curve adds an emit state and waits
// there while the previous result is still held on the output.
module point_to_polyline_min_distance_core import ppmd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MAG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [MAG_W-1:0]     in_point_b,
  input  logic [MAG_W-1:0]     in_point_v,
  input  logic                 in_first_point,
  input  logic                 in_last_point,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_W-1:0]     out_min_distance_sq,
  output logic                 out_found
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_SQX   = 5'd1;
  localparam logic [4:0] ST_SQY   = 5'd2;
  localparam logic [4:0] ST_DSUM  = 5'd3;
  localparam logic [4:0] ST_TEST  = 5'd4;
  localparam logic [4:0] ST_SA    = 5'd5;
  localparam logic [4:0] ST_SB    = 5'd6;
  localparam logic [4:0] ST_SC    = 5'd7;
  localparam logic [4:0] ST_SD    = 5'd8;
  localparam logic [4:0] ST_P0    = 5'd9;
  localparam logic [4:0] ST_P1    = 5'd10;
  localparam logic [4:0] ST_P2    = 5'd11;
  localparam logic [4:0] ST_P3    = 5'd12;
  localparam logic [4:0] ST_DIV   = 5'd13;
  localparam logic [4:0] ST_OFFER = 5'd14;
  localparam logic [4:0] ST_UPD   = 5'd15;
  localparam logic [4:0] ST_EMIT  = 5'd16;

  mag_t obs_v_r, obs_col_r, v_off_r, col_lim_r, mag_lim_r;

  logic [4:0] state_r, state_nxt;
  mag_t       v_r, v_nxt;
  col_t       col_r, col_nxt;
  logic       last_r, last_nxt;
  dif_t       dx_r, dx_nxt, dy_r, dy_nxt;
  dist_t      acc_r, acc_nxt, d_r, d_nxt, s_r, s_nxt, cand_r, cand_nxt;
  mag_t       wb_r [2], wb_nxt [2];
  mag_t       wv_r [2], wv_nxt [2];
  dist_t      wd_r [2], wd_nxt [2];
  logic [1:0] fill_r, fill_nxt;
  dist_t      best_r, best_nxt;
  logic       found_r, found_nxt;
  logic       seg_r, seg_nxt;
  logic [NUM_W-1:0] c_r, c_nxt;
  logic [PRD_W-1:0] ll_r, ll_nxt, hh_r, hh_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_min_r, out_min_nxt;
  logic             out_found_r, out_found_nxt;

  logic [DIF_W-1:0] mul_a, mul_b;
  logic [PRD_W-1:0] prod;
  div_req_t         dreq;
  div_rsp_t         drsp;

  logic             accept;
  col_t             in_col, col0, col1;
  dif_t             dv, dc;
  dist_t            dn;
  logic signed [DEN_W-1:0] c1, c2;
  logic [85:0]      num;
  logic             is_min;
  dist_t            prod_sat;

  ppmd_mul u_mul (.clk(clk), .op_a(mul_a), .op_b(mul_b), .prod(prod));
  ppmd_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  assign in_col = col_t'(mag_t'(in_point_b)) - col_t'(mag_t'(in_point_v));
  assign col1   = col_t'(wb_r[1]) - col_t'(wv_r[1]);
  assign col0   = col_t'(wb_r[0]) - col_t'(wv_r[0]);
  assign dv     = seg_r ? dif_t'(wv_r[0]) - dif_t'(wv_r[1]) : dif_t'(v_r) - dif_t'(wv_r[1]);
  assign dc     = seg_r ? dif_t'(col0) - dif_t'(col1) : dif_t'(col_r) - dif_t'(col1);
  assign dn     = seg_r ? wd_r[0] : d_r;
  assign c1     = $signed({2'b0, wd_r[1]}) + $signed({2'b0, s_r}) - $signed({2'b0, dn});
  assign c2     = $signed({2'b0, dn}) + $signed({2'b0, s_r}) - $signed({2'b0, wd_r[1]});
  // c = hi * 2^22 + lo, so c^2 = hi^2 * 2^44 + hi*lo * 2^23 + lo^2
  assign num    = {hh_r[DIST_W-1:0], 44'b0} + {19'b0, prod, 23'b0} + {42'b0, ll_r};
  assign is_min = (wd_r[1] <= d_r) && (wd_r[1] <= wd_r[0]) &&
                  (col_r < col_t'(col_lim_r)) && (v_r < mag_lim_r);
  // a single square of 2^21 or more already saturates
  assign prod_sat = (prod > {2'b0, DIST_MAX}) ? DIST_MAX : prod[DIST_W-1:0];

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_SQX: begin
        mul_a = abs_dif(dx_r);
        mul_b = abs_dif(dx_r);
      end
      ST_SQY: begin
        mul_a = abs_dif(dy_r);
        mul_b = abs_dif(dy_r);
      end
      ST_SA: begin
        mul_a = abs_dif(dv);
        mul_b = abs_dif(dv);
      end
      ST_SB: begin
        mul_a = abs_dif(dc);
        mul_b = abs_dif(dc);
      end
      ST_P0: begin
        mul_a = c_r[21:0];
        mul_b = c_r[21:0];
      end
      ST_P1: begin
        mul_a = {1'b0, c_r[42:22]};
        mul_b = {1'b0, c_r[42:22]};
      end
      ST_P2: begin
        mul_a = {1'b0, c_r[42:22]};
        mul_b = c_r[21:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    dreq.start  = (state_r == ST_P3);
    dreq.num_hi = num[85:43];
    dreq.num_lo = num[42:0];
    dreq.den    = {s_r, 2'b00};
  end

  always_comb begin
    state_nxt = state_r;
    v_nxt = v_r; col_nxt = col_r; last_nxt = last_r;
    dx_nxt = dx_r; dy_nxt = dy_r;
    acc_nxt = acc_r; d_nxt = d_r; s_nxt = s_r; cand_nxt = cand_r;
    wb_nxt = wb_r; wv_nxt = wv_r; wd_nxt = wd_r; fill_nxt = fill_r;
    best_nxt = best_r; found_nxt = found_r; seg_nxt = seg_r;
    c_nxt = c_r; ll_nxt = ll_r; hh_nxt = hh_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_min_nxt = out_min_r; out_found_nxt = out_found_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          v_nxt    = mag_t'(in_point_v);
          col_nxt  = in_col;
          last_nxt = in_last_point;
          dx_nxt   = dif_t'(in_col) - dif_t'(obs_col_r);
          dy_nxt   = dif_t'(mag_t'(in_point_v)) - dif_t'(obs_v_r) - dif_t'(v_off_r);
          if (in_first_point) begin
            wb_nxt = '{default: '0};
            wv_nxt = '{default: '0};
            wd_nxt = '{default: '0};
            fill_nxt = '0;
            best_nxt = '0;
            found_nxt = 1'b0;
          end
          state_nxt = ST_SQX;
        end
      end
      ST_SQX: state_nxt = ST_SQY;
      ST_SQY: begin
        acc_nxt = prod_sat;
        state_nxt = ST_DSUM;
      end
      ST_DSUM: begin
        d_nxt = sat_add(acc_r, prod);
        state_nxt = ST_TEST;
      end
      ST_TEST: begin
        seg_nxt = 1'b0;
        state_nxt = (fill_r == 2'd2 && is_min) ? ST_SA : ST_UPD;
      end
      ST_SA: state_nxt = ST_SB;
      ST_SB: begin
        acc_nxt = prod_sat;
        state_nxt = ST_SC;
      end
      ST_SC: begin
        s_nxt = sat_add(acc_r, prod);
        state_nxt = ST_SD;
      end
      ST_SD: begin
        // obtuse end angle or zero-length segment picks an endpoint
        priority if (c1 < 0) begin
          cand_nxt = wd_r[1];
          state_nxt = ST_OFFER;
        end else if (c2 < 0 || s_r == '0) begin
          cand_nxt = dn;
          state_nxt = ST_OFFER;
        end else begin
          c_nxt = c2[NUM_W-1:0];
          state_nxt = ST_P0;
        end
      end
      ST_P0: state_nxt = ST_P1;
      ST_P1: begin
        ll_nxt = prod;
        state_nxt = ST_P2;
      end
      ST_P2: begin
        hh_nxt = prod;
        state_nxt = ST_P3;
      end
      ST_P3: state_nxt = ST_DIV;
      ST_DIV: begin
        if (drsp.done) begin
          cand_nxt = (drsp.quo >= {1'b0, dn}) ? '0 : dn - drsp.quo[DIST_W-1:0];
          state_nxt = ST_OFFER;
        end
      end
      ST_OFFER: begin
        if (!found_r || cand_r < best_r) begin
          best_nxt = cand_r;
          found_nxt = 1'b1;
        end
        seg_nxt = 1'b1;
        state_nxt = seg_r ? ST_UPD : ST_SA;
      end
      ST_UPD: begin
        wb_nxt[0] = wb_r[1];
        wv_nxt[0] = wv_r[1];
        wd_nxt[0] = wd_r[1];
        wb_nxt[1] = mag_t'(col_r + col_t'(v_r));
        wv_nxt[1] = v_r;
        wd_nxt[1] = d_r;
        if (fill_r != 2'd2) fill_nxt = fill_r + 1'b1;
        state_nxt = last_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          out_min_nxt = !found_r ? '0 :
                        (best_r > {1'b0, OUT_MAX}) ? OUT_MAX : best_r[OUT_W-1:0];
          wb_nxt = '{default: '0};
          wv_nxt = '{default: '0};
          wd_nxt = '{default: '0};
          fill_nxt = '0;
          best_nxt = '0;
          found_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      obs_v_r     <= '0;
      obs_col_r   <= '0;
      v_off_r     <= V_OFFSET_RST;
      col_lim_r   <= COL_LIMIT_RST;
      mag_lim_r   <= MAG_LIMIT_RST;
      wb_r        <= '{default: '0};
      wv_r        <= '{default: '0};
      wd_r        <= '{default: '0};
      fill_r      <= '0;
      best_r      <= '0;
      found_r     <= 1'b0;
      seg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wb_r        <= wb_nxt;
      wv_r        <= wv_nxt;
      wd_r        <= wd_nxt;
      fill_r      <= fill_nxt;
      best_r      <= best_nxt;
      found_r     <= found_nxt;
      seg_r       <= seg_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_OBS_V:     obs_v_r   <= cfg_data;
          REG_OBS_COL:   obs_col_r <= cfg_data;
          REG_V_OFFSET:  v_off_r   <= cfg_data;
          REG_COL_LIMIT: col_lim_r <= cfg_data;
          REG_MAG_LIMIT: mag_lim_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    v_r         <= v_nxt;
    col_r       <= col_nxt;
    last_r      <= last_nxt;
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    acc_r       <= acc_nxt;
    d_r         <= d_nxt;
    s_r         <= s_nxt;
    cand_r      <= cand_nxt;
    c_r         <= c_nxt;
    ll_r        <= ll_nxt;
    hh_r        <= hh_nxt;
    out_min_r   <= out_min_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_min_distance_sq = out_min_r;
  assign out_found           = out_found_r;

endmodule
